// File: rtl/core/glpd_pkg.sv
// shared codes and types of the gif lzw pixel decoder
package glpd_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_PULL  = 2'd2;

  localparam logic [2:0] ST_PIXEL    = 3'd0;
  localparam logic [2:0] ST_NEED     = 3'd1;
  localparam logic [2:0] ST_END      = 3'd2;
  localparam logic [2:0] ST_OVER     = 3'd3;
  localparam logic [2:0] ST_ACCEPTED = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;
  localparam logic [2:0] ST_STARTED  = 3'd6;
  localparam logic [2:0] ST_BAD      = 3'd7;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RUN   = 3'd1;
  localparam logic [2:0] PH_END   = 3'd2;
  localparam logic [2:0] PH_BAD   = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  // datapath commands
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_SIMPLE  = 3'd1;
  localparam logic [2:0] OP_DECODE  = 3'd2;
  localparam logic [2:0] OP_RD_WALK = 3'd3;
  localparam logic [2:0] OP_EMIT    = 3'd4;
  localparam logic [2:0] OP_RD_LEN  = 3'd5;
  localparam logic [2:0] OP_SET_LEN = 3'd6;

  // outcome of one code extraction
  localparam logic [2:0] K_NEED  = 3'd0;
  localparam logic [2:0] K_CLEAR = 3'd1;
  localparam logic [2:0] K_EOI   = 3'd2;
  localparam logic [2:0] K_BAD   = 3'd3;
  localparam logic [2:0] K_CODE  = 3'd4;

  localparam logic [3:0] MAX_WIDTH = 4'd12;

  typedef struct packed {
    logic [2:0] op;
  } glpd_cmd_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       walking;
    logic [2:0] kind;
  } glpd_stat_t;

endpackage

// File: rtl/core/gif_lzw_pixel_decoder_core.sv
// top level of the gif lzw pixel decoder
//
// a word is taken when start is high and busy is low; in_mode selects
// start of image, offer of one stream byte (length or data) or pull of
// the next pixel. every word gives one result on out_status,
// out_pixel_address and out_pixel_index, shown for one cycle with
// out_strobe, the cycle after the last step of that word.
// start and byte words, and pulls before a start or after an end or error:
// result in the cycle after acceptance, busy never rises, so one word per cycle.
// pull that emits a pixel of a string in progress: a registered read of the
// code table, then the emit step, with busy high until the result.
// pull that decodes a new code: a decode step and the length lookup (read,
// then set) come first, plus a further decode step for every clear code met.
// the receiver cannot stall: each result must be taken in its cycle.
// the apb port (psel..pready) holds min_code_size at 0x0 and
// image_pixels at 0x4; write it only while idle.
// reset (rst_n low, synchronous) leaves the block idle, refusing bytes
// and pulls until a start word; table roots need no fill pass.
module gif_lzw_pixel_decoder_core #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int ADDR_BITS     = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_stream_byte,
  output logic                 out_strobe,
  output logic [2:0]           out_status,
  output logic [ADDR_BITS-1:0] out_pixel_address,
  output logic [7:0]           out_pixel_index,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  glpd_pkg::glpd_cmd_t  cmd;
  glpd_pkg::glpd_stat_t stat;

  assign pready = 1'b1;

  glpd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  glpd_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_stream_byte    (in_stream_byte),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_pixel_address (out_pixel_address),
    .out_pixel_index   (out_pixel_index)
  );

endmodule

// File: rtl/core/glpd_ram.sv
// generic single write, single registered read ram
module glpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/glpd_ctrl.sv
// sequencer of the decoder: accepts words and steps the datapath
module glpd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_mode,
  input  glpd_pkg::glpd_stat_t  stat,
  output glpd_pkg::glpd_cmd_t   cmd,
  output logic                  busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_LENW = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = glpd_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode == glpd_pkg::MODE_PULL &&
              (stat.phase == glpd_pkg::PH_RUN || stat.phase == glpd_pkg::PH_DRAIN)) begin
            state_nxt = S_STEP;
          end else begin
            cmd.op = glpd_pkg::OP_SIMPLE;
          end
        end
      end
      S_STEP: begin
        if (stat.walking) begin
          cmd.op    = glpd_pkg::OP_RD_WALK;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = glpd_pkg::OP_DECODE;
          if (stat.kind == glpd_pkg::K_CLEAR) begin
            state_nxt = S_STEP;
          end else if (stat.kind == glpd_pkg::K_CODE) begin
            state_nxt = S_LEN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LEN: begin
        cmd.op    = glpd_pkg::OP_RD_LEN;
        state_nxt = S_LENW;
      end
      S_LENW: begin
        cmd.op    = glpd_pkg::OP_SET_LEN;
        state_nxt = S_STEP;
      end
      S_EMIT: begin
        cmd.op    = glpd_pkg::OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/core/glpd_dp.sv
// datapath: bit cache, code table, string walk and result registers
module glpd_dp #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int ADDR_BITS     = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  glpd_pkg::glpd_cmd_t   cmd,
  output glpd_pkg::glpd_stat_t  stat,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_stream_byte,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  out_strobe,
  output logic [2:0]            out_status,
  output logic [ADDR_BITS-1:0]  out_pixel_address,
  output logic [7:0]            out_pixel_index
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int FW = ADDR_BITS + 1;
  localparam int PW = ((FW > 21) ? FW : 21) + 1;

  logic [3:0]  min_size_r, min_size_nxt;
  logic [20:0] img_pix_r, img_pix_nxt;
  logic [3:0]  lmin_r, lmin_nxt;
  logic [23:0] cache_r, cache_nxt;
  logic [4:0]  cbits_r, cbits_nxt;
  logic [7:0]  sub_left_r, sub_left_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic [12:0] nf_r, nf_nxt;
  logic        frozen_r, frozen_nxt;
  logic        widen_r, widen_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [11:0] prev_len_r, prev_len_nxt;
  logic [11:0] prev_code_r, prev_code_nxt;
  logic [FW-1:0] fo_r, fo_nxt;
  logic [11:0] walk_ent_r, walk_ent_nxt;
  logic [11:0] walk_left_r, walk_left_nxt;
  logic [11:0] walk_code_r, walk_code_nxt;
  logic [11:0] walk_len_r, walk_len_nxt;
  logic        add_end_r, add_end_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        strobe_r, strobe_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [7:0]  index_r, index_nxt;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  glpd_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // decode of the next code in the cache
  logic [3:0]  w;
  logic [8:0]  clear;
  logic [11:0] code;
  logic [2:0]  kind;
  logic        cfg_wr;

  assign clear = 9'd1 << lmin_r;
  assign w = (widen_r && cw_r < glpd_pkg::MAX_WIDTH) ? cw_r + 4'd1 : cw_r;
  assign code = cache_r[11:0] & ~(12'hFFF << w);

  always_comb begin
    if (cbits_r < {1'b0, w}) begin
      kind = glpd_pkg::K_NEED;
    end else if (code == {3'b000, clear}) begin
      kind = glpd_pkg::K_CLEAR;
    end else if (code == {3'b000, clear} + 12'd1) begin
      kind = glpd_pkg::K_EOI;
    end else if ({1'b0, code} >= 13'(TABLE_ENTRIES) || {1'b0, code} > nf_r ||
                 ({1'b0, code} == nf_r && (prev_len_r == 12'd0 || frozen_r))) begin
      kind = glpd_pkg::K_BAD;
    end else begin
      kind = glpd_pkg::K_CODE;
    end
  end

  assign stat.phase   = phase_r;
  assign stat.walking = (walk_left_r != 12'd0);
  assign stat.kind    = kind;

  // table entry as read, roots are implied below the clear code
  logic [11:0] rd_ent_addr;
  logic [31:0] entry;
  logic [11:0] e_len;
  assign rd_ent_addr = (cmd.op == glpd_pkg::OP_SET_LEN) ? walk_code_r : walk_ent_r;
  assign entry = (rd_ent_addr < {3'b000, clear}) ? {12'd1, 12'd0, rd_ent_addr[7:0]} : rdata;
  assign e_len = entry[31:20];

  // pixel position of the emitted character
  logic [PW-1:0] pos;
  logic [FW:0]   fo_sum;
  logic          over;
  assign pos = PW'(fo_r) + PW'(walk_left_r) - PW'(1);
  assign over = (pos >= PW'(img_pix_r)) || (pos[PW-1:ADDR_BITS] != '0);
  assign fo_sum = {1'b0, fo_r} + (FW+1)'(walk_len_r);

  logic [12:0] nf_inc;
  assign nf_inc = nf_r + 13'd1;

  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {11'd0, img_pix_r} : {28'd0, min_size_r};

  always_comb begin
    min_size_nxt  = min_size_r;
    img_pix_nxt   = img_pix_r;
    lmin_nxt      = lmin_r;
    cache_nxt     = cache_r;
    cbits_nxt     = cbits_r;
    sub_left_nxt  = sub_left_r;
    cw_nxt        = cw_r;
    nf_nxt        = nf_r;
    frozen_nxt    = frozen_r;
    widen_nxt     = widen_r;
    first_nxt     = first_r;
    prev_len_nxt  = prev_len_r;
    prev_code_nxt = prev_code_r;
    fo_nxt        = fo_r;
    walk_ent_nxt  = walk_ent_r;
    walk_left_nxt = walk_left_r;
    walk_code_nxt = walk_code_r;
    walk_len_nxt  = walk_len_r;
    add_end_nxt   = add_end_r;
    phase_nxt     = phase_r;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    index_nxt     = index_r;
    we            = 1'b0;
    waddr         = nf_r[IW-1:0];
    wdata         = {prev_len_r + 12'd1, prev_code_r, first_r};
    re            = 1'b0;
    raddr         = walk_ent_r[IW-1:0];

    if (cfg_wr) begin
      if (paddr[2]) begin
        img_pix_nxt = pwdata[20:0];
      end else begin
        min_size_nxt = pwdata[3:0];
      end
    end

    unique case (cmd.op)
      glpd_pkg::OP_SIMPLE: begin
        strobe_nxt = 1'b1;
        status_nxt = glpd_pkg::ST_REFUSED;
        addr_nxt   = '0;
        index_nxt  = '0;
        case (in_mode)
          glpd_pkg::MODE_START: begin
            lmin_nxt = (min_size_r < 4'd2) ? 4'd2 :
                       ((min_size_r > 4'd8) ? 4'd8 : min_size_r);
            cw_nxt        = lmin_nxt + 4'd1;
            nf_nxt        = (13'd1 << lmin_nxt) + 13'd2;
            frozen_nxt    = 1'b0;
            widen_nxt     = 1'b0;
            prev_len_nxt  = '0;
            prev_code_nxt = '0;
            cache_nxt     = '0;
            cbits_nxt     = '0;
            sub_left_nxt  = '0;
            first_nxt     = '0;
            fo_nxt        = '0;
            walk_ent_nxt  = '0;
            walk_left_nxt = '0;
            walk_code_nxt = '0;
            walk_len_nxt  = '0;
            add_end_nxt   = 1'b0;
            phase_nxt     = glpd_pkg::PH_RUN;
            status_nxt    = glpd_pkg::ST_STARTED;
          end
          glpd_pkg::MODE_BYTE: begin
            if (phase_r == glpd_pkg::PH_RUN) begin
              if (sub_left_r == 8'd0) begin
                if (in_stream_byte == 8'd0) begin
                  phase_nxt = glpd_pkg::PH_DRAIN;
                end else begin
                  sub_left_nxt = in_stream_byte;
                end
                status_nxt = glpd_pkg::ST_ACCEPTED;
              end else if (cbits_r <= 5'd16) begin
                cache_nxt    = cache_r | ({16'd0, in_stream_byte} << cbits_r);
                cbits_nxt    = cbits_r + 5'd8;
                sub_left_nxt = sub_left_r - 8'd1;
                status_nxt   = glpd_pkg::ST_ACCEPTED;
              end
            end
          end
          glpd_pkg::MODE_PULL: begin
            if (phase_r == glpd_pkg::PH_END) begin
              status_nxt = glpd_pkg::ST_END;
            end else if (phase_r == glpd_pkg::PH_BAD) begin
              status_nxt = glpd_pkg::ST_BAD;
            end
          end
          default: begin
            status_nxt = glpd_pkg::ST_REFUSED;
          end
        endcase
      end
      glpd_pkg::OP_DECODE: begin
        cw_nxt    = w;
        widen_nxt = 1'b0;
        addr_nxt  = '0;
        index_nxt = '0;
        if (kind == glpd_pkg::K_NEED) begin
          strobe_nxt = 1'b1;
          if (phase_r == glpd_pkg::PH_DRAIN) begin
            phase_nxt  = glpd_pkg::PH_END;
            status_nxt = glpd_pkg::ST_END;
          end else begin
            status_nxt = glpd_pkg::ST_NEED;
          end
        end else begin
          cache_nxt = cache_r >> w;
          cbits_nxt = cbits_r - {1'b0, w};
          if (kind == glpd_pkg::K_CLEAR) begin
            cw_nxt        = lmin_r + 4'd1;
            nf_nxt        = {4'd0, clear} + 13'd2;
            frozen_nxt    = 1'b0;
            widen_nxt     = 1'b0;
            prev_len_nxt  = '0;
            prev_code_nxt = '0;
          end else if (kind == glpd_pkg::K_EOI) begin
            strobe_nxt = 1'b1;
            phase_nxt  = glpd_pkg::PH_END;
            status_nxt = glpd_pkg::ST_END;
          end else if (kind == glpd_pkg::K_BAD) begin
            strobe_nxt = 1'b1;
            phase_nxt  = glpd_pkg::PH_BAD;
            status_nxt = glpd_pkg::ST_BAD;
          end else begin
            // kwkwk: the new entry is the previous string plus its first character
            add_end_nxt = 1'b0;
            if ({1'b0, code} == nf_r) begin
              we     = 1'b1;
              nf_nxt = nf_inc;
              if (nf_inc >= 13'(TABLE_ENTRIES)) begin
                frozen_nxt = 1'b1;
              end else if ((nf_inc & (nf_inc - 13'd1)) == 13'd0 &&
                           w < glpd_pkg::MAX_WIDTH) begin
                widen_nxt = 1'b1;
              end
            end else if (prev_len_r != 12'd0 && !frozen_r) begin
              add_end_nxt = 1'b1;
            end
            walk_code_nxt = code;
            walk_ent_nxt  = code;
          end
        end
      end
      glpd_pkg::OP_RD_LEN: begin
        re    = 1'b1;
        raddr = walk_code_r[IW-1:0];
      end
      glpd_pkg::OP_SET_LEN: begin
        walk_len_nxt  = (e_len == 12'd0) ? 12'd1 : e_len;
        walk_left_nxt = walk_len_nxt;
      end
      glpd_pkg::OP_RD_WALK: begin
        re = 1'b1;
      end
      glpd_pkg::OP_EMIT: begin
        strobe_nxt    = 1'b1;
        status_nxt    = over ? glpd_pkg::ST_OVER : glpd_pkg::ST_PIXEL;
        addr_nxt      = pos[ADDR_BITS-1:0];
        index_nxt     = entry[7:0];
        walk_ent_nxt  = entry[19:8];
        walk_left_nxt = walk_left_r - 12'd1;
        if (walk_left_r == 12'd1) begin
          // string done: the deferred entry takes this first character
          if (add_end_r) begin
            we     = 1'b1;
            wdata  = {prev_len_r + 12'd1, prev_code_r, entry[7:0]};
            nf_nxt = nf_inc;
            if (nf_inc >= 13'(TABLE_ENTRIES)) begin
              frozen_nxt = 1'b1;
            end else if ((nf_inc & (nf_inc - 13'd1)) == 13'd0 &&
                         cw_r < glpd_pkg::MAX_WIDTH) begin
              widen_nxt = 1'b1;
            end
          end
          add_end_nxt   = 1'b0;
          prev_code_nxt = walk_code_r;
          prev_len_nxt  = walk_len_r;
          first_nxt     = entry[7:0];
          fo_nxt        = (fo_sum > {1'b0, {FW{1'b1}}}) ? {FW{1'b1}} : fo_sum[FW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r  <= 4'd8;
      img_pix_r   <= 21'd1048576;
      lmin_r      <= 4'd8;
      cache_r     <= '0;
      cbits_r     <= '0;
      sub_left_r  <= '0;
      cw_r        <= 4'd9;
      nf_r        <= 13'd258;
      frozen_r    <= 1'b0;
      widen_r     <= 1'b0;
      first_r     <= '0;
      prev_len_r  <= '0;
      prev_code_r <= '0;
      fo_r        <= '0;
      walk_ent_r  <= '0;
      walk_left_r <= '0;
      walk_code_r <= '0;
      walk_len_r  <= '0;
      add_end_r   <= 1'b0;
      phase_r     <= glpd_pkg::PH_IDLE;
      strobe_r    <= 1'b0;
    end else begin
      min_size_r  <= min_size_nxt;
      img_pix_r   <= img_pix_nxt;
      lmin_r      <= lmin_nxt;
      cache_r     <= cache_nxt;
      cbits_r     <= cbits_nxt;
      sub_left_r  <= sub_left_nxt;
      cw_r        <= cw_nxt;
      nf_r        <= nf_nxt;
      frozen_r    <= frozen_nxt;
      widen_r     <= widen_nxt;
      first_r     <= first_nxt;
      prev_len_r  <= prev_len_nxt;
      prev_code_r <= prev_code_nxt;
      fo_r        <= fo_nxt;
      walk_ent_r  <= walk_ent_nxt;
      walk_left_r <= walk_left_nxt;
      walk_code_r <= walk_code_nxt;
      walk_len_r  <= walk_len_nxt;
      add_end_r   <= add_end_nxt;
      phase_r     <= phase_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
    index_r  <= index_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_index   = index_r;

endmodule

// File: rtl/core/glpd_checker.sv
// port level checks of the decoder and their binding
module glpd_props #(
  parameter int ADDR_BITS = 20
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input logic [2:0]           out_status,
  input logic [ADDR_BITS-1:0] out_pixel_address,
  input logic [7:0]           out_pixel_index
);

  // an accepted word either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted word neither answered nor in progress");

  // leaving busy always delivers the result of that word
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy ended without a result");

  // no result while a word is still being worked on
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result shown while busy");

  // only pixel words carry an address and index
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != glpd_pkg::ST_PIXEL && out_status != glpd_pkg::ST_OVER)
      |-> (out_pixel_address == '0 && out_pixel_index == 8'd0))
    else $error("non pixel result with payload");

endmodule

bind gif_lzw_pixel_decoder_core glpd_props #(.ADDR_BITS(ADDR_BITS)) u_glpd_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_pixel_address (out_pixel_address),
  .out_pixel_index   (out_pixel_index)
);
